>>> rtl/core/scle_pkg.sv
// Shared constants, types and key translation tables for the scancode line editor.
`timescale 1ns / 1ps
package scle_pkg;

    localparam int LINE_BYTES = 128;
    localparam int TERMINALS  = 3;

    localparam int IDX_W  = $clog2(LINE_BYTES);
    localparam int ADDR_W = $clog2(TERMINALS * LINE_BYTES);
    localparam int TERM_W = 2;
    localparam int POS_W  = 7;
    localparam int LEN_W  = 8;
    localparam int MOD_W  = 6;

    // modifier bit positions
    localparam int MOD_SHIFT  = 0;
    localparam int MOD_CAPS   = 1;
    localparam int MOD_CTRL   = 2;
    localparam int MOD_ALT    = 3;
    localparam int MOD_NUM    = 4;
    localparam int MOD_SCROLL = 5;

    // set-1 scancodes
    localparam logic [7:0] SC_RELEASE    = 8'h80;
    localparam logic [7:0] SC_LSHIFT     = 8'h2A;
    localparam logic [7:0] SC_RSHIFT     = 8'h36;
    localparam logic [7:0] SC_CAPS       = 8'h3A;
    localparam logic [7:0] SC_CTRL       = 8'h1D;
    localparam logic [7:0] SC_ALT        = 8'h38;
    localparam logic [7:0] SC_NUM        = 8'h45;
    localparam logic [7:0] SC_SCROLL     = 8'h46;
    localparam logic [7:0] SC_L          = 8'h26;
    localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;
    localparam logic [7:0] SC_CTRL_REL   = 8'h9D;
    localparam logic [7:0] SC_ALT_REL    = 8'hB8;

    // characters with special handling
    localparam logic [7:0] CH_NONE = 8'h00;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;

    typedef struct packed {
        logic             echo_valid;
        logic [7:0]       echo_char;
        logic             erase_tab;
        logic             clear_screen;
        logic             store_valid;
        logic [POS_W-1:0] store_pos;
        logic             line_done;
        logic [LEN_W-1:0] line_length;
        logic [MOD_W-1:0] modifiers;
    } result_t;

    function automatic logic is_letter(input logic [6:0] code);
        logic hit;
        hit = code inside {[7'h10:7'h19], [7'h1E:7'h26], [7'h2C:7'h32]};
        return hit;
    endfunction

    function automatic logic [7:0] rom_char(input logic [6:0] code, input logic upper);
        logic [7:0] ch;
        case (code)
            7'h01: ch = 8'h1B;
            7'h02: ch = upper ? "!" : "1";
            7'h03: ch = upper ? "@" : "2";
            7'h04: ch = upper ? "#" : "3";
            7'h05: ch = upper ? "$" : "4";
            7'h06: ch = upper ? "%" : "5";
            7'h07: ch = upper ? "^" : "6";
            7'h08: ch = upper ? "&" : "7";
            7'h09: ch = upper ? "*" : "8";
            7'h0A: ch = upper ? "(" : "9";
            7'h0B: ch = upper ? ")" : "0";
            7'h0C: ch = upper ? "_" : "-";
            7'h0D: ch = upper ? "+" : "=";
            7'h0E: ch = CH_BS;
            7'h0F: ch = CH_TAB;
            7'h10: ch = upper ? "Q" : "q";
            7'h11: ch = upper ? "W" : "w";
            7'h12: ch = upper ? "E" : "e";
            7'h13: ch = upper ? "R" : "r";
            7'h14: ch = upper ? "T" : "t";
            7'h15: ch = upper ? "Y" : "y";
            7'h16: ch = upper ? "U" : "u";
            7'h17: ch = upper ? "I" : "i";
            7'h18: ch = upper ? "O" : "o";
            7'h19: ch = upper ? "P" : "p";
            7'h1A: ch = upper ? "{" : "[";
            7'h1B: ch = upper ? "}" : "]";
            7'h1C: ch = CH_LF;
            7'h1E: ch = upper ? "A" : "a";
            7'h1F: ch = upper ? "S" : "s";
            7'h20: ch = upper ? "D" : "d";
            7'h21: ch = upper ? "F" : "f";
            7'h22: ch = upper ? "G" : "g";
            7'h23: ch = upper ? "H" : "h";
            7'h24: ch = upper ? "J" : "j";
            7'h25: ch = upper ? "K" : "k";
            7'h26: ch = upper ? "L" : "l";
            7'h27: ch = upper ? ":" : ";";
            7'h28: ch = upper ? 8'h22 : 8'h27;
            7'h29: ch = upper ? 8'h7E : 8'h60;
            7'h2B: ch = upper ? 8'h7C : 8'h5C;
            7'h2C: ch = upper ? "Z" : "z";
            7'h2D: ch = upper ? "X" : "x";
            7'h2E: ch = upper ? "C" : "c";
            7'h2F: ch = upper ? "V" : "v";
            7'h30: ch = upper ? "B" : "b";
            7'h31: ch = upper ? "N" : "n";
            7'h32: ch = upper ? "M" : "m";
            7'h33: ch = upper ? "<" : ",";
            7'h34: ch = upper ? ">" : ".";
            7'h35: ch = upper ? "?" : "/";
            7'h37: ch = "*";
            7'h39: ch = " ";
            7'h4A: ch = "-";
            7'h4E: ch = "+";
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/core/scle_key_if.sv
// Scancode input channel.
`timescale 1ns / 1ps
interface scle_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] scancode;

    modport source (output valid, output scancode, input ready);
    modport sink   (input valid, input scancode, output ready);
endinterface

>>> rtl/core/scle_cfg_if.sv
// Configuration write channel carrying the active terminal select.
`timescale 1ns / 1ps
interface scle_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] active_terminal;

    modport source (output valid, output active_terminal, input ready);
    modport sink   (input valid, input active_terminal, output ready);
endinterface

>>> rtl/core/scle_result_if.sv
// Result channel of the line editor.
`timescale 1ns / 1ps
interface scle_result_if;
    logic       valid;
    logic       ready;
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       erase_tab;
    logic       clear_screen;
    logic       store_valid;
    logic [6:0] store_pos;
    logic       line_done;
    logic [7:0] line_length;
    logic [5:0] modifiers;

    modport source (output valid, output echo_valid, output echo_char, output erase_tab,
                    output clear_screen, output store_valid, output store_pos,
                    output line_done, output line_length, output modifiers, input ready);
    modport sink   (input valid, input echo_valid, input echo_char, input erase_tab,
                    input clear_screen, input store_valid, input store_pos,
                    input line_done, input line_length, input modifiers, output ready);
endinterface

>>> rtl/core/scancode_line_editor.sv
// Top level: set-1 scancode translator and per-terminal line editor.
`timescale 1ns / 1ps
// Each request is registered in stage B (s1_reg) on accept, then in the output
//   register (out_reg) once that is free or being taken.
// Throughput: one request per cycle unless the output stalls; the line store is a single-port
//   synchronous RAM touched at most once per request (a write, or a read for backspace).
// The backspace read returns in the second stage, which picks erase_tab or a BS echo.
// Reset clears modifier flags, line indexes, terminal select and the pipeline valids;
//   the line store is not cleared and needs no clearing pass.
module scancode_line_editor
    import scle_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    scle_cfg_if.sink      cfg,
    scle_key_if.sink      keys,
    scle_result_if.source result
);

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    logic [TERM_W-1:0] term_reg;
    logic [MOD_W-1:0]  mods_reg;
    logic [MOD_W-1:0]  mods_next;
    logic [IDX_W-1:0]  line_idx_reg [TERMINALS];

    // line store: TERMINALS rows of LINE_BYTES, one port
    logic [7:0]        line_mem [TERMINALS * LINE_BYTES];
    logic [7:0]        rd_data_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;

    // pipeline
    logic    acc;
    logic    s1_valid_reg;
    logic    s1_bs_reg;
    result_t s1_reg;
    logic    s1_move;
    logic    out_valid_reg;
    result_t out_reg;
    result_t res_a;
    result_t res_b;
    logic    bs_a;

    // stage A decode
    logic [7:0]        sc;
    logic              term_ok;
    logic [TERM_W-1:0] t_sel;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  idx_next;
    logic              idx_we;
    logic              char_key;
    logic              clr;
    logic              upper;
    logic [7:0]        ch;
    logic [ADDR_W-1:0] row_base;

    // ------------------------------------------------------------------
    // Handshakes: stage A is the accept cycle, stage B holds the request
    // while the RAM read completes, then the output register.
    // ------------------------------------------------------------------
    assign acc        = keys.valid && keys.ready;
    assign s1_move    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign keys.ready = !s1_valid_reg || s1_move;
    assign cfg.ready  = 1'b1;

    assign sc       = keys.scancode;
    assign term_ok  = int'(term_reg) < TERMINALS;
    assign t_sel    = term_ok ? term_reg : '0;
    assign idx      = line_idx_reg[t_sel];
    assign row_base = ADDR_W'(ADDR_W'(t_sel) * ADDR_W'(LINE_BYTES));

    // modifier update and key classification
    always_comb
    begin
        mods_next = mods_reg;
        char_key  = 1'b0;
        clr       = 1'b0;
        if (sc[7])
        begin
            case (sc)
                SC_LSHIFT_REL, SC_RSHIFT_REL: mods_next[MOD_SHIFT] = 1'b0;
                SC_CTRL_REL:                  mods_next[MOD_CTRL]  = 1'b0;
                SC_ALT_REL:                   mods_next[MOD_ALT]   = 1'b0;
                default:                      mods_next = mods_reg;
            endcase
        end
        else
        begin
            case (sc)
                SC_LSHIFT, SC_RSHIFT: mods_next[MOD_SHIFT]  = 1'b1;
                SC_CAPS:              mods_next[MOD_CAPS]   = ~mods_reg[MOD_CAPS];
                SC_CTRL:              mods_next[MOD_CTRL]   = 1'b1;
                SC_ALT:               mods_next[MOD_ALT]    = 1'b1;
                SC_NUM:               mods_next[MOD_NUM]    = ~mods_reg[MOD_NUM];
                SC_SCROLL:            mods_next[MOD_SCROLL] = ~mods_reg[MOD_SCROLL];
                default:
                begin
                    if (mods_reg[MOD_CTRL] && sc == SC_L)
                        clr = 1'b1;
                    else
                        char_key = 1'b1;
                end
            endcase
        end
    end

    // caps lock flips the shift choice for letters only
    assign upper = mods_reg[MOD_SHIFT] ^ (mods_reg[MOD_CAPS] && is_letter(sc[6:0]));
    assign ch    = rom_char(sc[6:0], upper);

    // line edit: everything but the tab check is known at accept time
    always_comb
    begin
        res_a              = '0;
        res_a.clear_screen = clr;
        res_a.modifiers    = mods_next;
        bs_a               = 1'b0;
        idx_we             = 1'b0;
        idx_next           = idx;
        mem_we             = 1'b0;
        mem_re             = 1'b0;
        mem_addr           = ADDR_W'(row_base + ADDR_W'(idx));
        mem_wdata          = ch;
        if (char_key && term_ok)
        begin
            if (ch == CH_BS)
            begin
                if (idx != '0)
                begin
                    bs_a     = 1'b1;
                    mem_re   = acc;
                    mem_addr = ADDR_W'(row_base + ADDR_W'(idx - IDX_W'(1)));
                    idx_we   = 1'b1;
                    idx_next = idx - IDX_W'(1);
                end
            end
            else if (ch == CH_LF)
            begin
                // newline always fits: the index never passes LINE_BYTES-1
                mem_we            = acc;
                res_a.echo_valid  = 1'b1;
                res_a.echo_char   = ch;
                res_a.store_valid = 1'b1;
                res_a.store_pos   = POS_W'(idx);
                res_a.line_done   = 1'b1;
                res_a.line_length = LEN_W'(LEN_W'(idx) + LEN_W'(1));
                idx_we            = 1'b1;
                idx_next          = '0;
            end
            else if (ch != CH_NONE && int'(idx) < LINE_BYTES - 1)
            begin
                mem_we            = acc;
                res_a.echo_valid  = 1'b1;
                res_a.echo_char   = ch;
                res_a.store_valid = 1'b1;
                res_a.store_pos   = POS_W'(idx);
                idx_we            = 1'b1;
                idx_next          = IDX_W'(idx + IDX_W'(1));
            end
        end
        if (!res_a.line_done)
            res_a.line_length = term_ok ? LEN_W'(idx_next) : '0;
    end

    // stage B: the character below the cursor decides how backspace echoes
    always_comb
    begin
        res_b = s1_reg;
        if (s1_bs_reg)
        begin
            if (rd_data_reg == CH_TAB)
                res_b.erase_tab = 1'b1;
            else
            begin
                res_b.echo_valid = 1'b1;
                res_b.echo_char  = CH_BS;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg      <= '0;
            mods_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TERMINALS; i++)
                line_idx_reg[i] <= '0;
        end
        else
        begin
            if (cfg.valid)
                term_reg <= cfg.active_terminal;
            if (acc)
            begin
                mods_reg <= mods_next;
                if (idx_we)
                    line_idx_reg[t_sel] <= idx_next;
            end
            if (acc)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_reg    <= res_a;
            s1_bs_reg <= bs_a;
        end
        if (s1_move)
            out_reg <= res_b;
    end

    // line store RAM, read data registered; reads only on backspace accepts
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= line_mem[mem_addr];
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign result.valid        = out_valid_reg;
    assign result.echo_valid   = out_reg.echo_valid;
    assign result.echo_char    = out_reg.echo_char;
    assign result.erase_tab    = out_reg.erase_tab;
    assign result.clear_screen = out_reg.clear_screen;
    assign result.store_valid  = out_reg.store_valid;
    assign result.store_pos    = out_reg.store_pos;
    assign result.line_done    = out_reg.line_done;
    assign result.line_length  = out_reg.line_length;
    assign result.modifiers    = out_reg.modifiers;

`ifndef SYNTHESIS
    // one RAM port: a request either writes or reads the store
    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("line store read and write in the same cycle");

    // a stalled backspace must keep its read data
    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_bs_reg && !s1_move) |=> $stable(rd_data_reg))
        else $error("line store read data changed under a stalled request");

    // backspace moves the cursor down by exactly one
    a_bs_index: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && bs_a) |=> (line_idx_reg[$past(t_sel)] == $past(idx) - IDX_W'(1)))
        else $error("backspace did not decrement the line index");

    // a tab erase never comes with an echo
    a_erase_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.erase_tab && result.echo_valid))
        else $error("erase_tab and echo_valid both set");

    // a completed line was stored and has a nonzero length
    a_line_done: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.line_done) |->
            (result.store_valid && result.line_length != '0))
        else $error("line_done without a stored newline");
`endif

endmodule

>>> verif/tb_scancode_line_editor.sv
// Self-checking testbench for the scancode line editor: keystrokes in, per-field result checks.
`timescale 1ns / 1ps
module tb_scancode_line_editor;
    import scle_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the pipe
    localparam int SETTLE_CYCLES = 4;     // settle margin after the last result
    localparam int PHASE_KEYS    = 100;
    localparam int PRINT_CAP     = 100;

    // scancodes not named in the package
    localparam logic [7:0] KEY_NULL      = 8'h00;
    localparam logic [7:0] KEY_ESC       = 8'h01;
    localparam logic [7:0] KEY_1         = 8'h02;
    localparam logic [7:0] KEY_BKSP      = 8'h0E;
    localparam logic [7:0] KEY_TAB       = 8'h0F;
    localparam logic [7:0] KEY_ENTER     = 8'h1C;
    localparam logic [7:0] KEY_A         = 8'h1E;
    localparam logic [7:0] KEY_BACKTICK  = 8'h29;
    localparam logic [7:0] KEY_STAR      = 8'h37;
    localparam logic [7:0] KEY_SPACE     = 8'h39;
    localparam logic [7:0] KEY_F1        = 8'h3B;
    localparam logic [7:0] KEY_PAD_MINUS = 8'h4A;
    localparam logic [7:0] KEY_PAD_PLUS  = 8'h4E;
    localparam logic [7:0] KEY_TOP       = 8'h7F;
    localparam logic [7:0] REL_TOP       = 8'hFF;

    // first code of each character row
    localparam logic [7:0] ROW_DIGITS = 8'h02;
    localparam logic [7:0] ROW_UPPER  = 8'h10;
    localparam logic [7:0] ROW_HOME   = 8'h1E;
    localparam logic [7:0] ROW_LOWER  = 8'h2B;

    localparam logic [7:0] LOCK_AND_HOLD_KEYS [11] = '{
        SC_LSHIFT, SC_RSHIFT, SC_LSHIFT_REL, SC_RSHIFT_REL, SC_CTRL, SC_CTRL_REL,
        SC_ALT, SC_ALT_REL, SC_CAPS, SC_NUM, SC_SCROLL
    };

    localparam logic [7:0] OPENING_KEYS [30] = '{
        KEY_A, SC_LSHIFT, KEY_A, KEY_1, SC_LSHIFT_REL,        // plain and shifted
        SC_CAPS, KEY_A, KEY_1,                                // caps hits letters only
        SC_RSHIFT, KEY_A, SC_RSHIFT_REL, SC_CAPS,             // caps with shift cancels
        KEY_TAB, KEY_BKSP, KEY_BKSP,                          // tab erase, then plain BS
        KEY_F1, KEY_NULL,                                     // keys with no character
        SC_CTRL, SC_L, SC_CTRL_REL,                           // screen clear
        SC_ALT, SC_ALT_REL, SC_NUM, SC_SCROLL,
        REL_TOP,                                              // ignored release
        KEY_ENTER, KEY_BKSP,                                  // BS on an empty line
        KEY_TOP, SC_L, KEY_ENTER
    };

    localparam logic [7:0] DEAD_TERMINAL_KEYS [7] = '{
        KEY_A, KEY_BKSP, KEY_ENTER, SC_CTRL, SC_L, SC_CTRL_REL, SC_NUM
    };

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        result_t     want;
        logic [7:0]  code;
        int unsigned seq;
    } edit_expect_t;

    // Line editor prediction plus the queue of results still owed by the block.
    class line_edit_tracker;
        logic [MOD_W-1:0]  mods;
        logic [TERM_W-1:0] term_sel;
        int unsigned       line_idx [TERMINALS];
        logic [7:0]        line_mem [TERMINALS][LINE_BYTES];
        logic [7:0]        lower_map [128];
        logic [7:0]        upper_map [128];
        edit_expect_t      pending_results [$];
        int unsigned       keys_taken;
        int unsigned       fail_count;

        function new();
            string      lo_rows [4];
            string      hi_rows [4];
            logic [7:0] row_base [4];
            lo_rows  = '{"1234567890-=", "qwertyuiop[]", "asdfghjkl;'", "\\zxcvbnm,./"};
            hi_rows  = '{"!@#$%^&*()_+", "QWERTYUIOP{}", "ASDFGHJKL:\"", "|ZXCVBNM<>?"};
            row_base = '{ROW_DIGITS, ROW_UPPER, ROW_HOME, ROW_LOWER};
            mods       = '0;
            term_sel   = '0;
            keys_taken = 0;
            fail_count = 0;
            foreach (line_idx[t])
                line_idx[t] = 0;
            foreach (lower_map[i])
            begin
                lower_map[i] = CH_NONE;
                upper_map[i] = CH_NONE;
            end
            for (int r = 0; r < 4; r++)
                for (int i = 0; i < lo_rows[r].len(); i++)
                    put(int'(row_base[r]) + i, lo_rows[r][i], hi_rows[r][i]);
            put(KEY_ESC, 8'h1B, 8'h1B);
            put(KEY_BKSP, CH_BS, CH_BS);
            put(KEY_TAB, CH_TAB, CH_TAB);
            put(KEY_ENTER, CH_LF, CH_LF);
            put(KEY_BACKTICK, 8'h60, 8'h7E);
            put(KEY_STAR, "*", "*");
            put(KEY_SPACE, " ", " ");
            put(KEY_PAD_MINUS, "-", "-");
            put(KEY_PAD_PLUS, "+", "+");
        endfunction

        function void put(int code, logic [7:0] lo, logic [7:0] hi);
            lower_map[code] = lo;
            upper_map[code] = hi;
        endfunction

        function bit letter_key(logic [6:0] k);
            return (k >= 7'h10 && k <= 7'h19) || (k >= 7'h1E && k <= 7'h26) ||
                   (k >= 7'h2C && k <= 7'h32);
        endfunction

        function void set_terminal(logic [TERM_W-1:0] t);
            term_sel = t;
        endfunction

        // One scancode in, one result out; updates flags and line state.
        function result_t predict_edit(logic [7:0] code);
            result_t     r;
            bit          term_ok;
            bit          upper;
            logic [7:0]  ch;
            int unsigned t;
            int unsigned idx;
            r       = '0;
            term_ok = (term_sel < TERMINALS);
            t       = term_ok ? int'(term_sel) : 0;
            if (code[7])
            begin
                if (code == SC_LSHIFT_REL || code == SC_RSHIFT_REL)
                    mods[MOD_SHIFT] = 1'b0;
                else if (code == SC_CTRL_REL)
                    mods[MOD_CTRL] = 1'b0;
                else if (code == SC_ALT_REL)
                    mods[MOD_ALT] = 1'b0;
            end
            else if (code == SC_LSHIFT || code == SC_RSHIFT)
                mods[MOD_SHIFT] = 1'b1;
            else if (code == SC_CAPS)
                mods[MOD_CAPS] = ~mods[MOD_CAPS];
            else if (code == SC_CTRL)
                mods[MOD_CTRL] = 1'b1;
            else if (code == SC_ALT)
                mods[MOD_ALT] = 1'b1;
            else if (code == SC_NUM)
                mods[MOD_NUM] = ~mods[MOD_NUM];
            else if (code == SC_SCROLL)
                mods[MOD_SCROLL] = ~mods[MOD_SCROLL];
            else if (mods[MOD_CTRL] && code == SC_L)
                r.clear_screen = 1'b1;
            else if (term_ok)
            begin
                upper = mods[MOD_SHIFT] ^ (mods[MOD_CAPS] & letter_key(code[6:0]));
                ch    = upper ? upper_map[code[6:0]] : lower_map[code[6:0]];
                idx   = line_idx[t];
                if (ch == CH_BS)
                begin
                    if (idx != 0)
                    begin
                        if (line_mem[t][idx - 1] == CH_TAB)
                            r.erase_tab = 1'b1;
                        else
                        begin
                            r.echo_valid = 1'b1;
                            r.echo_char  = CH_BS;
                        end
                        line_idx[t] = idx - 1;
                    end
                end
                else if (ch == CH_LF)
                begin
                    line_mem[t][idx] = ch;
                    r.echo_valid     = 1'b1;
                    r.echo_char      = ch;
                    r.store_valid    = 1'b1;
                    r.store_pos      = POS_W'(idx);
                    r.line_done      = 1'b1;
                    r.line_length    = LEN_W'(idx + 1);
                    line_idx[t]      = 0;
                end
                else if (ch != CH_NONE && idx < LINE_BYTES - 1)
                begin
                    line_mem[t][idx] = ch;
                    r.echo_valid     = 1'b1;
                    r.echo_char      = ch;
                    r.store_valid    = 1'b1;
                    r.store_pos      = POS_W'(idx);
                    line_idx[t]      = idx + 1;
                end
            end
            if (!r.line_done)
                r.line_length = term_ok ? LEN_W'(line_idx[t]) : '0;
            r.modifiers = mods;
            return r;
        endfunction

        function void take_scancode(logic [7:0] code);
            edit_expect_t e;
            e.want = predict_edit(code);
            e.code = code;
            e.seq  = keys_taken;
            keys_taken++;
            pending_results.push_back(e);
        endfunction

        task report(string msg);
            fail_count++;
            if (fail_count <= PRINT_CAP)
                $display("MISMATCH: %s", msg);
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want, edit_expect_t e);
            if (got !== want)
                report($sformatf("key #%0d (code %02h) %s: got %02h, expected %02h",
                                 e.seq, e.code, name, got, want));
        endtask

        task match_result(result_t got);
            edit_expect_t e;
            if (pending_results.size() == 0)
            begin
                report("result with no request outstanding");
                return;
            end
            e = pending_results.pop_front();
            check_field("echo_valid", 8'(got.echo_valid), 8'(e.want.echo_valid), e);
            check_field("echo_char", got.echo_char, e.want.echo_char, e);
            check_field("erase_tab", 8'(got.erase_tab), 8'(e.want.erase_tab), e);
            check_field("clear_screen", 8'(got.clear_screen), 8'(e.want.clear_screen), e);
            check_field("store_valid", 8'(got.store_valid), 8'(e.want.store_valid), e);
            check_field("store_pos", 8'(got.store_pos), 8'(e.want.store_pos), e);
            check_field("line_done", 8'(got.line_done), 8'(e.want.line_done), e);
            check_field("line_length", got.line_length, e.want.line_length, e);
            check_field("modifiers", 8'(got.modifiers), 8'(e.want.modifiers), e);
        endtask

        task close_out();
            if (pending_results.size() != 0)
                report($sformatf("%0d requests never answered", pending_results.size()));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    scle_cfg_if    cfg_bus();
    scle_key_if    key_bus();
    scle_result_if res_bus();

    line_edit_tracker tracker;

    // receiver side: only the ready process writes rx_ready
    logic       rx_ready     = 1'b0;
    int         stall_pct    = 0;     // set by the stimulus with NBAs
    logic [3:0] hold_trigger = '0;    // bumped by the stimulus to start a hold-off
    logic [3:0] hold_seen    = '0;
    int         hold_left    = 0;

    // sender side
    int gap_pct   = 0;
    int keys_sent = 0;    // requests that the block acts on (ignored releases not counted)
    int hold_at   = -1;
    int cycles    = 0;

    assign res_bus.ready = rx_ready;

    scancode_line_editor uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .keys   (key_bus),
        .result (res_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop; a correct run ends far below this.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever hold_trigger moves.
    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rx_ready <= 1'b0;
        end
        else
            rx_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Monitor: everything sampled at the edge where the handshake completes.
    // The key request is noted before the result check, so ordering never
    // depends on the latency.
    always @(posedge clk)
    begin
        result_t seen;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
                tracker.set_terminal(cfg_bus.active_terminal);
            if (key_bus.valid && key_bus.ready)
                tracker.take_scancode(key_bus.scancode);
            if (res_bus.valid && res_bus.ready)
            begin
                seen.echo_valid   = res_bus.echo_valid;
                seen.echo_char    = res_bus.echo_char;
                seen.erase_tab    = res_bus.erase_tab;
                seen.clear_screen = res_bus.clear_screen;
                seen.store_valid  = res_bus.store_valid;
                seen.store_pos    = res_bus.store_pos;
                seen.line_done    = res_bus.line_done;
                seen.line_length  = res_bus.line_length;
                seen.modifiers    = res_bus.modifiers;
                tracker.match_result(seen);
            end
        end
    end

    // Offers one scancode and returns at the edge it is taken. valid stays
    // high on return so back-to-back requests keep it asserted unless a gap is drawn.
    task automatic send_key(input logic [7:0] code);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            key_bus.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
        end
        key_bus.valid    <= 1'b1;
        key_bus.scancode <= code;
        do @(posedge clk); while (!key_bus.ready);
        if (!code[7] || code == SC_LSHIFT_REL || code == SC_RSHIFT_REL ||
            code == SC_CTRL_REL || code == SC_ALT_REL)
        begin
            keys_sent++;
            if (keys_sent == hold_at)
                hold_trigger <= hold_trigger + 1'b1;
        end
    endtask

    // Stop offering and wait until every request has its result; checked at
    // the falling edge so the monitor has settled for the cycle.
    task automatic wait_drained();
        key_bus.valid <= 1'b0;
        do @(negedge clk); while (tracker.pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Terminal select changes only while the block is idle.
    task automatic select_terminal(input logic [TERM_W-1:0] t);
        wait_drained();
        cfg_bus.valid           <= 1'b1;
        cfg_bus.active_terminal <= t;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [7:0] char_key();
        int unsigned pick;
        pick = $urandom_range(0, 49);
        if (pick < 12)
            return ROW_DIGITS + 8'(pick);
        else if (pick < 24)
            return ROW_UPPER + 8'(pick - 12);
        else if (pick < 36)
            return ROW_HOME + 8'(pick - 24);
        else if (pick < 47)
            return ROW_LOWER + 8'(pick - 36);
        else if (pick == 47)
            return KEY_STAR;
        else if (pick == 48)
            return KEY_SPACE;
        case ($urandom_range(0, 2))
            0: return KEY_ESC;
            1: return KEY_PAD_MINUS;
            default: return KEY_PAD_PLUS;
        endcase
    endfunction

    function automatic logic [7:0] noise_key();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            return 8'($urandom_range(0, 255));
        else if (pick < 45)
            return LOCK_AND_HOLD_KEYS[$urandom_range(0, 10)];
        else if (pick < 60)
            return KEY_BKSP;
        else if (pick < 70)
            return KEY_TAB;
        else if (pick < 78)
            return KEY_ENTER;
        return char_key();
    endfunction

    // A typed line: mostly characters with the odd edit, closed by Enter.
    // Long lines run the index into the full-line limit.
    task automatic type_line(input bit force_long);
        int unsigned len;
        int unsigned odds;
        int unsigned pick;
        odds = 12;
        len  = $urandom_range(1, 12);
        if (force_long || $urandom_range(0, 7) == 0)
        begin
            len  = $urandom_range(128, 160);
            odds = 60;
        end
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, odds - 1);
            if (pick == 0)
                send_key(KEY_BKSP);
            else if (pick == 1)
                send_key(KEY_TAB);
            else if (pick == 2)
                send_key(LOCK_AND_HOLD_KEYS[$urandom_range(0, 10)]);
            else
                send_key(char_key());
        end
        // sometimes rub out the line, often past its start
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, len + 2)) send_key(KEY_BKSP);
        send_key(KEY_ENTER);
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 8)) send_key(noise_key());
    endtask

    // One phase: terminal select, idle pattern, then lines and noise.
    // Phases with a hold-off open with a long line and stall the receiver
    // 30 requests in, while the sender keeps offering.
    task automatic run_phase(input logic [TERM_W-1:0] t, input idle_mode_t mode,
                             input bit with_hold);
        int target;
        bit drained;
        select_terminal(t);
        case (mode)
            IDLE_NONE:
            begin
                gap_pct   = 0;
                stall_pct <= 0;
            end
            IDLE_SENDER:
            begin
                gap_pct   = 68;
                stall_pct <= 0;
            end
            IDLE_RECEIVER:
            begin
                gap_pct   = 0;
                stall_pct <= 68;
            end
            default:
            begin
                gap_pct   = 31;
                stall_pct <= 31;
            end
        endcase
        target  = keys_sent + PHASE_KEYS;
        hold_at = with_hold ? keys_sent + 30 : -1;
        drained = 1'b0;
        if (with_hold)
            type_line(1'b1);
        while (keys_sent < target)
        begin
            // sender pause halfway through: let every result come home
            if (!drained && keys_sent >= target - PHASE_KEYS / 2)
            begin
                wait_drained();
                drained = 1'b1;
            end
            if ($urandom_range(0, 9) < 7)
                type_line(1'b0);
            else
                noise_burst();
        end
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        key_bus.valid           = 1'b0;
        key_bus.scancode        = '0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.active_terminal = '0;
        tracker = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on terminal 0 (reset select)
        foreach (OPENING_KEYS[i])
            send_key(OPENING_KEYS[i]);
        // select past the last terminal: edits go nowhere, flags still move
        select_terminal(2'd3);
        foreach (DEAD_TERMINAL_KEYS[i])
            send_key(DEAD_TERMINAL_KEYS[i]);

        run_phase(2'd0, IDLE_NONE, 1'b1);
        run_phase(2'd3, IDLE_SENDER, 1'b0);
        run_phase(2'd1, IDLE_RECEIVER, 1'b0);
        run_phase(2'd2, IDLE_BOTH, 1'b0);
        run_phase(2'd2, IDLE_NONE, 1'b1);
        run_phase(2'd0, IDLE_SENDER, 1'b0);
        run_phase(2'd3, IDLE_RECEIVER, 1'b0);
        run_phase(2'd1, IDLE_BOTH, 1'b0);

        wait_drained();
        tracker.close_out();
        if (tracker.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
